// ----- rtl/core/gcb_pkg.sv -----
package gcb_pkg;

  // datapath widths
  localparam int unsigned XW        = 34;  // rotation x/y, Q30 with headroom
  localparam int unsigned SC_W      = 33;  // sine/cosine after quadrant fix
  localparam int unsigned VW        = 36;  // vectoring x/y
  localparam int unsigned FRAC      = 30;
  localparam int unsigned LANES     = 3;   // start lat, end lat, dlon
  localparam int unsigned BEARING_W = 25;
  localparam int unsigned DEG_SHIFT = 19;  // 360 * 65536 = 45 * 2^19
  localparam int unsigned DEG_MUL   = 45;

  localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;

  // lane order inside a rotation cell
  localparam int unsigned LANE_LAT1 = 0;
  localparam int unsigned LANE_LAT2 = 1;
  localparam int unsigned LANE_DLON = 2;

  // atan(2^-k), 2^32 per turn
  function automatic logic [31:0] atan_tab(input int unsigned k);
    logic [31:0] t;
    unique case (k % 32)
      0:  t = 32'h20000000;  1:  t = 32'h12E4051E;
      2:  t = 32'h09FB385B;  3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;  9:  t = 32'h00145F2F;
      10: t = 32'h000A2F98;  11: t = 32'h000517CC;
      12: t = 32'h00028BE6;  13: t = 32'h000145F3;
      14: t = 32'h0000A2FA;  15: t = 32'h0000517D;
      16: t = 32'h000028BE;  17: t = 32'h0000145F;
      18: t = 32'h00000A30;  19: t = 32'h00000518;
      20: t = 32'h0000028C;  21: t = 32'h00000146;
      22: t = 32'h000000A3;  23: t = 32'h00000051;
      24: t = 32'h00000029;  25: t = 32'h00000014;
      26: t = 32'h0000000A;  27: t = 32'h00000005;
      28: t = 32'h00000003;  29: t = 32'h00000001;
      30: t = 32'h00000001;  default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/core/gcb_if.sv -----
interface gcb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_lat;
  logic [31:0] start_lon;
  logic [31:0] end_lat;
  logic [31:0] end_lon;

  modport source (output valid, start_lat, start_lon, end_lat, end_lon, input ready);
  modport sink   (input valid, start_lat, start_lon, end_lat, end_lon, output ready);
endinterface

interface gcb_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] bearing_deg;
  logic        points_coincide;

  modport source (output valid, bearing_deg, points_coincide, input ready);
  modport sink   (input valid, bearing_deg, points_coincide, output ready);
endinterface

// ----- rtl/core/gcb_rot_cell.sv -----
// One rotation CORDIC step for the three sine/cosine lanes.
module gcb_rot_cell #(
  parameter int unsigned STAGE      = 0,
  parameter int unsigned ANGLE_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic signed [gcb_pkg::XW-1:0]        x_i    [gcb_pkg::LANES],
  input  logic signed [gcb_pkg::XW-1:0]        y_i    [gcb_pkg::LANES],
  input  logic signed [ANGLE_BITS:0]           z_i    [gcb_pkg::LANES],
  input  logic        [gcb_pkg::LANES-1:0]     flip_i,
  output logic                                 valid_o,
  output logic signed [gcb_pkg::XW-1:0]        x_o    [gcb_pkg::LANES],
  output logic signed [gcb_pkg::XW-1:0]        y_o    [gcb_pkg::LANES],
  output logic signed [ANGLE_BITS:0]           z_o    [gcb_pkg::LANES],
  output logic        [gcb_pkg::LANES-1:0]     flip_o
);

  localparam int unsigned K     = STAGE % 32;
  localparam logic [63:0] T64   = 64'(gcb_pkg::atan_tab(K));
  localparam logic [63:0] TSCL  = (ANGLE_BITS >= 32) ? (T64 << (ANGLE_BITS - 32))
                                                     : (T64 >> (32 - ANGLE_BITS));
  localparam logic signed [ANGLE_BITS:0] TAB = (ANGLE_BITS + 1)'(TSCL);

  logic signed [gcb_pkg::XW-1:0] x_d [gcb_pkg::LANES];
  logic signed [gcb_pkg::XW-1:0] y_d [gcb_pkg::LANES];
  logic signed [ANGLE_BITS:0]    z_d [gcb_pkg::LANES];

  // rotate toward z = 0
  always_comb begin
    for (int l = 0; l < gcb_pkg::LANES; l++) begin
      if (!z_i[l][ANGLE_BITS]) begin
        x_d[l] = x_i[l] - (y_i[l] >>> K);
        y_d[l] = y_i[l] + (x_i[l] >>> K);
        z_d[l] = z_i[l] - TAB;
      end else begin
        x_d[l] = x_i[l] + (y_i[l] >>> K);
        y_d[l] = y_i[l] - (x_i[l] >>> K);
        z_d[l] = z_i[l] + TAB;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      flip_o <= flip_i;
    end
  end

endmodule

// ----- rtl/core/gcb_vec_cell.sv -----
// One vectoring CORDIC step of the arctangent.
module gcb_vec_cell #(
  parameter int unsigned STAGE      = 0,
  parameter int unsigned ANGLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [gcb_pkg::VW-1:0] x_i,
  input  logic signed [gcb_pkg::VW-1:0] y_i,
  input  logic signed [ANGLE_BITS:0]    z_i,
  input  logic                          zero_i,
  output logic                          valid_o,
  output logic signed [gcb_pkg::VW-1:0] x_o,
  output logic signed [gcb_pkg::VW-1:0] y_o,
  output logic signed [ANGLE_BITS:0]    z_o,
  output logic                          zero_o
);

  localparam int unsigned K     = STAGE % 32;
  localparam logic [63:0] T64   = 64'(gcb_pkg::atan_tab(K));
  localparam logic [63:0] TSCL  = (ANGLE_BITS >= 32) ? (T64 << (ANGLE_BITS - 32))
                                                     : (T64 >> (32 - ANGLE_BITS));
  localparam logic signed [ANGLE_BITS:0] TAB = (ANGLE_BITS + 1)'(TSCL);

  logic signed [gcb_pkg::VW-1:0] x_d, y_d;
  logic signed [ANGLE_BITS:0]    z_d;

  // drive y toward zero, accumulate angle
  always_comb begin
    if (!y_i[gcb_pkg::VW-1]) begin
      x_d = x_i + (y_i >>> K);
      y_d = y_i - (x_i >>> K);
      z_d = z_i + TAB;
    end else begin
      x_d = x_i - (y_i >>> K);
      y_d = y_i + (x_i >>> K);
      z_d = z_i - TAB;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      zero_o <= zero_i;
    end
  end

endmodule

// ----- rtl/core/great_circle_bearing_core.sv -----
// Initial great-circle bearing from a start to an end coordinate.
// in_i:  request of start_lat, start_lon, end_lat, end_lon (binary angles,
//        2^31 = pi). Taken when valid and ready are both high.
// out_o: bearing_deg (degrees * 65536, [0,360)) and points_coincide.
// Throughput: one request per cycle while the output queue has a free slot.
// The datapath is a chain of registered stages: the input fold register,
// CORDIC_STAGES rotation cells (three lanes each) for sine/cosine, the
// fold-undo register, three product stages, the pre-rotation register,
// CORDIC_STAGES vectoring cells for the arctangent and a scaling stage.
// Results land in a two-entry output queue. The whole chain advances while
// the queue has a free slot, so requests keep flowing while one result
// waits; with both slots held by a stalled receiver the chain freezes and
// in_i.ready drops until out_o.ready takes an entry.
// Reset clears all valid bits and the queue; datapath registers are not reset.
module great_circle_bearing_core #(
  parameter int unsigned CORDIC_STAGES = 24,
  parameter int unsigned ANGLE_BITS    = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  gcb_in_if.sink    in_i,
  gcb_out_if.source out_o
);

  localparam int unsigned AB     = ANGLE_BITS;
  localparam int unsigned UP_SH  = (AB >= 32) ? (AB - 32) : 0;
  localparam int unsigned DN_SH  = (AB < 32) ? (32 - AB) : 0;
  localparam int unsigned XW     = gcb_pkg::XW;
  localparam int unsigned SC_W   = gcb_pkg::SC_W;
  localparam int unsigned VW     = gcb_pkg::VW;
  localparam int unsigned LANES  = gcb_pkg::LANES;
  localparam int unsigned BW     = gcb_pkg::BEARING_W;
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
  localparam logic [AB-1:0] HALF    = AB'(1) << (AB - 1);
  localparam logic signed [AB:0] Z_QTR = (AB + 1)'(1) << (AB - 2);

  logic en;

  // binary angle to internal width
  function automatic logic [AB-1:0] to_int(input logic [31:0] v);
    logic [63:0] t;
    t = ({32'd0, v} << UP_SH) >> DN_SH;
    return t[AB-1:0];
  endfunction

  // ---------------- input: quadrant fold ----------------
  logic [AB-1:0]    ang   [LANES];
  logic [AB-1:0]    asum  [LANES];
  logic [AB-1:0]    afold [LANES];
  logic [31:0]      dlon32;
  logic [LANES-1:0] flip;

  logic signed [XW-1:0] rx [CORDIC_STAGES+1][LANES];
  logic signed [XW-1:0] ry [CORDIC_STAGES+1][LANES];
  logic signed [AB:0]   rz [CORDIC_STAGES+1][LANES];
  logic [LANES-1:0]     rf [CORDIC_STAGES+1];
  logic                 rv [CORDIC_STAGES+1];

  always_comb begin
    dlon32 = in_i.end_lon - in_i.start_lon;
    ang[gcb_pkg::LANE_LAT1] = to_int(in_i.start_lat);
    ang[gcb_pkg::LANE_LAT2] = to_int(in_i.end_lat);
    ang[gcb_pkg::LANE_DLON] = to_int(dlon32);
    for (int l = 0; l < LANES; l++) begin
      asum[l]  = ang[l] + QUARTER;
      flip[l]  = asum[l][AB-1];
      afold[l] = flip[l] ? (ang[l] - HALF) : ang[l];
    end
  end

  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv[0] <= 1'b0;
    end else if (en) begin
      rv[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        rx[0][l] <= gcb_pkg::GAIN_Q30;
        ry[0][l] <= '0;
        rz[0][l] <= {afold[l][AB-1], afold[l]};
      end
      rf[0] <= flip;
    end
  end

  // ---------------- rotation chain ----------------
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    gcb_rot_cell #(.STAGE(i), .ANGLE_BITS(AB)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (rv[i]),
      .x_i     (rx[i]),
      .y_i     (ry[i]),
      .z_i     (rz[i]),
      .flip_i  (rf[i]),
      .valid_o (rv[i+1]),
      .x_o     (rx[i+1]),
      .y_o     (ry[i+1]),
      .z_o     (rz[i+1]),
      .flip_o  (rf[i+1])
    );
  end

  // ---------------- undo quadrant fold ----------------
  logic signed [SC_W-1:0] sn_q [LANES];
  logic signed [SC_W-1:0] cs_q [LANES];
  logic                   v_neg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        cs_q[l] <= SC_W'(rf[CORDIC_STAGES][l] ? -rx[CORDIC_STAGES][l] : rx[CORDIC_STAGES][l]);
        sn_q[l] <= SC_W'(rf[CORDIC_STAGES][l] ? -ry[CORDIC_STAGES][l] : ry[CORDIC_STAGES][l]);
      end
    end
  end

  // ---------------- products, first level ----------------
  logic signed [2*SC_W-1:0] p_num, p_c1s2, p_s1c2;
  logic signed [SC_W-1:0]   num_a_q, c1s2_a_q, s1c2_a_q, cd_a_q;
  logic                     v_ma_q;

  assign p_num  = sn_q[gcb_pkg::LANE_DLON] * cs_q[gcb_pkg::LANE_LAT2];
  assign p_c1s2 = cs_q[gcb_pkg::LANE_LAT1] * sn_q[gcb_pkg::LANE_LAT2];
  assign p_s1c2 = sn_q[gcb_pkg::LANE_LAT1] * cs_q[gcb_pkg::LANE_LAT2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_a_q  <= p_num[SC_W+gcb_pkg::FRAC-1:gcb_pkg::FRAC];
      c1s2_a_q <= p_c1s2[SC_W+gcb_pkg::FRAC-1:gcb_pkg::FRAC];
      s1c2_a_q <= p_s1c2[SC_W+gcb_pkg::FRAC-1:gcb_pkg::FRAC];
      cd_a_q   <= cs_q[gcb_pkg::LANE_DLON];
    end
  end

  // ---------------- products, second level ----------------
  logic signed [2*SC_W-1:0] p_tri;
  logic signed [SC_W-1:0]   num_b_q, c1s2_b_q, tri_b_q;
  logic                     v_mb_q;

  assign p_tri = s1c2_a_q * cd_a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_b_q  <= num_a_q;
      c1s2_b_q <= c1s2_a_q;
      tri_b_q  <= p_tri[SC_W+gcb_pkg::FRAC-1:gcb_pkg::FRAC];
    end
  end

  // ---------------- numerator / denominator ----------------
  logic signed [SC_W:0]   den_c_q;
  logic signed [SC_W-1:0] num_c_q;
  logic                   v_mc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_c_q <= num_b_q;
      den_c_q <= {c1s2_b_q[SC_W-1], c1s2_b_q} - {tri_b_q[SC_W-1], tri_b_q};
    end
  end

  // ---------------- vectoring pre-rotation ----------------
  logic signed [VW-1:0] vx [CORDIC_STAGES+1];
  logic signed [VW-1:0] vy [CORDIC_STAGES+1];
  logic signed [AB:0]   vz [CORDIC_STAGES+1];
  logic                 vzero [CORDIC_STAGES+1];
  logic                 vv [CORDIC_STAGES+1];
  logic signed [VW-1:0] pre_x, pre_y, ext_x, ext_y;
  logic signed [AB:0]   pre_z;

  always_comb begin
    ext_x = VW'(den_c_q);
    ext_y = VW'(num_c_q);
    pre_x = ext_x;
    pre_y = ext_y;
    pre_z = '0;
    if (ext_x[VW-1]) begin
      if (!ext_y[VW-1]) begin
        pre_x = ext_y;
        pre_y = -ext_x;
        pre_z = Z_QTR;
      end else begin
        pre_x = -ext_y;
        pre_y = ext_x;
        pre_z = -Z_QTR;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx[0]    <= pre_x;
      vy[0]    <= pre_y;
      vz[0]    <= pre_z;
      vzero[0] <= (num_c_q == '0) && (den_c_q == '0);
    end
  end

  // valid bits of the top-level stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_neg_q <= 1'b0;
      v_ma_q  <= 1'b0;
      v_mb_q  <= 1'b0;
      v_mc_q  <= 1'b0;
      vv[0]   <= 1'b0;
    end else if (en) begin
      v_neg_q <= rv[CORDIC_STAGES];
      v_ma_q  <= v_neg_q;
      v_mb_q  <= v_ma_q;
      v_mc_q  <= v_mb_q;
      vv[0]   <= v_mc_q;
    end
  end

  // ---------------- vectoring chain ----------------
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    gcb_vec_cell #(.STAGE(i), .ANGLE_BITS(AB)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vv[i]),
      .x_i     (vx[i]),
      .y_i     (vy[i]),
      .z_i     (vz[i]),
      .zero_i  (vzero[i]),
      .valid_o (vv[i+1]),
      .x_o     (vx[i+1]),
      .y_o     (vy[i+1]),
      .z_o     (vz[i+1]),
      .zero_o  (vzero[i+1])
    );
  end

  // ---------------- angle to degrees * 65536 ----------------
  logic [AB-1:0]    fin_ang;
  logic [AB+5:0]    deg_p;
  logic [AB+24:0]   deg_w;
  logic [BW-1:0]    deg_q;
  logic             zero_q;
  logic             v_deg_q;

  assign fin_ang = vz[CORDIC_STAGES][AB-1:0];
  assign deg_p   = (AB + 6)'(fin_ang) * (AB + 6)'(gcb_pkg::DEG_MUL);
  assign deg_w   = {deg_p, gcb_pkg::DEG_SHIFT'(0)} >> AB;

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_q  <= vzero[CORDIC_STAGES] ? '0 : deg_w[BW-1:0];
      zero_q <= vzero[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_deg_q <= 1'b0;
    end else if (en) begin
      v_deg_q <= vv[CORDIC_STAGES];
    end
  end

  // ---------------- two-entry output queue ----------------
  logic [BW-1:0] qb_q [2];
  logic          qc_q [2];
  logic          q_head_q, q_head_d;
  logic [1:0]    q_cnt_q, q_cnt_d;
  logic          q_wr, q_rd;
  logic          q_tail;

  assign en     = (q_cnt_q != 2'd2);
  assign q_wr   = en && v_deg_q;
  assign q_rd   = out_o.valid && out_o.ready;
  assign q_tail = q_head_q ^ q_cnt_q[0];

  always_comb begin
    q_cnt_d  = q_cnt_q + 2'(q_wr) - 2'(q_rd);
    q_head_d = q_head_q ^ q_rd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q  <= '0;
      q_head_q <= 1'b0;
    end else begin
      q_cnt_q  <= q_cnt_d;
      q_head_q <= q_head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_wr) begin
      qb_q[q_tail] <= deg_q;
      qc_q[q_tail] <= zero_q;
    end
  end

  assign out_o.valid           = (q_cnt_q != 2'd0);
  assign out_o.bearing_deg     = qb_q[q_head_q];
  assign out_o.points_coincide = qc_q[q_head_q];

  // ---------------- assertions ----------------
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q != 2'd3)
    else $error("output queue count out of range");

  a_coincide_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.points_coincide |-> out_o.bearing_deg == '0)
    else $error("coincident points with nonzero bearing");

  a_bearing_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.bearing_deg <= 25'd23592959)
    else $error("bearing beyond 360 degrees");

  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_cnt_q == 2'd2) && !out_o.ready |=> (q_cnt_q == 2'd2) && $stable(q_head_q))
    else $error("full queue changed without a read");

endmodule
